// ----- sv/linear_blend_skinning_defines.svh -----
// Assertion helpers shared by the checker file.
`ifndef LINEAR_BLEND_SKINNING_DEFINES_SVH
`define LINEAR_BLEND_SKINNING_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LBS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LBS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lbs_pkg;

    // Stream widths
    localparam int S_TDATA_W = 160;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 1;
    localparam int CFG_W     = 9;

    // Input beat layout
    localparam int BONE_LSB     = 0;
    localparam int ELEM_LSB     = 8;
    localparam int VALUE_LSB    = 12;
    localparam int VX_LSB       = 44;
    localparam int VY_LSB       = 76;
    localparam int VZ_LSB       = 108;
    localparam int WEIGHT_LSB   = 140;
    localparam int TUSER_OP     = 0;
    localparam int TUSER_NORMAL = 1;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_INFL = 1'b1;

    // Matrix shape and sequencer limits
    localparam int         MAT_ELEMS  = 12;
    localparam logic [3:0] LAST_ELEM  = 4'd11;
    localparam logic [5:0] MAC_LAST   = 6'd11;
    localparam logic [5:0] DRAIN_LAST = 6'd3;
    localparam logic [5:0] SQ_LAST    = 6'd2;
    localparam logic [5:0] SQRT_LAST  = 6'd32;
    localparam logic [5:0] DIV_LAST   = 6'd18;
    localparam logic [1:0] COMP_LAST  = 2'd2;

    // Arithmetic constants
    localparam logic [16:0] WEIGHT_ONE     = 17'd65536;
    localparam logic [7:0]  SHORT_SQ_LIMIT = 8'd43;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_NINIT,
        ST_SHIFT,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       load_wr;
        logic       capture;
        logic       rd_issue;
        logic [3:0] rd_elem;
        logic       norm_init;
        logic       shift_step;
        logic       sq_step;
        logic [1:0] comp;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       div_init;
        logic       div_step;
        logic       div_last;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic bone_ok;
        logic item_normal;
        logic item_last;
        logic short_now;
        logic aligned;
        logic out_free;
    } sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [31:0] r;
        if ((&x[49:31]) || !(|x[49:31]))
            r = x[31:0];
        else if (x[49])
            r = 32'sh8000_0000;
        else
            r = 32'sh7FFF_FFFF;
        return r;
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] x);
        logic signed [47:0] r;
        if ((&x[49:47]) || !(|x[49:47]))
            r = x[47:0];
        else if (x[49])
            r = 48'sh8000_0000_0000;
        else
            r = 48'sh7FFF_FFFF_FFFF;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/linear_blend_skinning.sv -----
// Load beat: taken without leaving idle. Influence beat on a valid bone: 12 matrix RAM reads
// through one read port, then a multiply/accumulate drain; skipped bone: no reads.
// Last point: norm init, then emit to the output register. Last normal: adds up to 27 align
// shifts, 3 squares, the square-root steps and the divider steps for each of the 3 components.
// The output register holds a result while the next beats are taken.
// Reset (rst_n low, async): clears control, accumulators and bone_count; matrix RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module linear_blend_skinning #(
    parameter int NUM_BONES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: bone, element, value, vx, vy, vz, weight, zero fill
    input  logic [lbs_pkg::S_TDATA_W-1:0] s_tdata,
    // s_tuser: op, is_normal
    input  logic [lbs_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // m_tdata: out_x, out_y, out_z
    output logic [lbs_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: out_is_normal
    output logic [lbs_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_we,
    input  logic [lbs_pkg::CFG_W-1:0]     cfg_data
);

    import lbs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lbs_dp #(
        .NUM_BONES (NUM_BONES)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// ----- sv/lbs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbs_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 3072,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/lbs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  lbs_pkg::sts_t sts,
    output lbs_pkg::cmd_t cmd
);

    import lbs_pkg::*;

    state_t     state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic [1:0] comp_reg, comp_next;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 6'd1;
        comp_next  = comp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_tvalid && (sts.op == OP_INFL))
                begin
                    if (sts.bone_ok)
                        state_next = ST_MAC;
                    else if (sts.item_last)
                        state_next = ST_NINIT;
                end
            end
            ST_MAC:
            begin
                if (cnt_reg == MAC_LAST)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == DRAIN_LAST)
                    state_next = sts.item_last ? ST_NINIT : ST_IDLE;
            end
            ST_NINIT:
            begin
                cnt_next   = '0;
                state_next = (!sts.item_normal || sts.short_now) ? ST_EMIT : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cnt_next = '0;
                if (sts.aligned)
                    state_next = ST_SQ;
            end
            ST_SQ:
            begin
                if (cnt_reg == SQ_LAST)
                begin
                    state_next = ST_SQRT;
                    cnt_next   = '0;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == SQRT_LAST)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    comp_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                begin
                    cnt_next = '0;
                    if (comp_reg == COMP_LAST)
                        state_next = ST_EMIT;
                    else
                        comp_next = comp_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready       = (state_reg == ST_IDLE);
        cmd            = '0;
        cmd.load_wr    = s_tready && s_tvalid && (sts.op == OP_LOAD);
        cmd.capture    = s_tready && s_tvalid && (sts.op == OP_INFL);
        cmd.rd_issue   = (state_reg == ST_MAC);
        cmd.rd_elem    = cnt_reg[3:0];
        cmd.norm_init  = (state_reg == ST_NINIT);
        cmd.shift_step = (state_reg == ST_SHIFT) && !sts.aligned;
        cmd.sq_step    = (state_reg == ST_SQ);
        cmd.comp       = (state_reg == ST_SQ) ? cnt_reg[1:0] : comp_reg;
        cmd.sqrt_init  = (state_reg == ST_SQRT) && (cnt_reg == '0);
        cmd.sqrt_step  = (state_reg == ST_SQRT) && (cnt_reg != '0);
        cmd.div_init   = (state_reg == ST_DIV) && (cnt_reg == '0);
        cmd.div_step   = (state_reg == ST_DIV) && (cnt_reg != '0);
        cmd.div_last   = (cnt_reg == DIV_LAST);
        cmd.emit       = (state_reg == ST_EMIT) && sts.out_free;
    end

endmodule

`default_nettype wire

// ----- sv/lbs_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lbs_dp #(
    parameter int NUM_BONES = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [lbs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [lbs_pkg::S_TUSER_W-1:0]    s_tuser,
    input  logic                             s_tlast,
    input  logic                             cfg_we,
    input  logic [lbs_pkg::CFG_W-1:0]        cfg_data,
    input  lbs_pkg::cmd_t                    cmd,
    output lbs_pkg::sts_t                    sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [lbs_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [lbs_pkg::M_TUSER_W-1:0]    m_tuser
);

    import lbs_pkg::*;

    localparam int MAT_DEPTH = NUM_BONES * MAT_ELEMS;
    localparam int AW        = $clog2(MAT_DEPTH);

    // Input fields
    logic [7:0]         in_bone;
    logic [3:0]         in_elem;
    logic [31:0]        in_value;
    logic signed [31:0] in_v [3];
    logic [16:0]        in_weight;
    logic [AW-1:0]      in_addr;

    assign in_bone   = s_tdata[BONE_LSB +: 8];
    assign in_elem   = s_tdata[ELEM_LSB +: 4];
    assign in_value  = s_tdata[VALUE_LSB +: 32];
    assign in_v[0]   = s_tdata[VX_LSB +: 32];
    assign in_v[1]   = s_tdata[VY_LSB +: 32];
    assign in_v[2]   = s_tdata[VZ_LSB +: 32];
    assign in_weight = s_tdata[WEIGHT_LSB +: 17];
    assign in_addr   = AW'(12'({in_bone, 3'b000}) + 12'({in_bone, 2'b00}) + 12'(in_elem));

    // Configuration
    logic [CFG_W-1:0] bone_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bone_count_reg <= '0;
        else if (cfg_we)
            bone_count_reg <= cfg_data;
    end

    // Item capture
    logic signed [31:0] v_reg [3];
    logic [16:0]        w_reg;
    logic               normal_reg;
    logic               last_reg;
    logic [AW-1:0]      base_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            v_reg[0]   <= in_v[0];
            v_reg[1]   <= in_v[1];
            v_reg[2]   <= in_v[2];
            w_reg      <= (in_weight > WEIGHT_ONE) ? WEIGHT_ONE : in_weight;
            normal_reg <= s_tuser[TUSER_NORMAL];
            last_reg   <= s_tlast;
            base_reg   <= AW'(12'({in_bone, 3'b000}) + 12'({in_bone, 2'b00}));
        end
    end

    // Matrix memory
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    assign ram_we    = cmd.load_wr && (in_elem <= LAST_ELEM) && (32'(in_bone) < NUM_BONES);
    assign ram_raddr = base_reg + AW'(cmd.rd_elem);

    lbs_ram #(
        .WIDTH (32),
        .DEPTH (MAT_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_addr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Pipeline tags
    logic       s1_valid_reg, p_valid_reg, trow_valid_reg, wp_valid_reg;
    logic [3:0] s1_elem_reg, p_elem_reg;
    logic [1:0] trow_row_reg, wp_row_reg;
    logic       row_end;

    assign row_end = p_valid_reg && (p_elem_reg[1:0] == 2'd3);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            p_valid_reg    <= 1'b0;
            trow_valid_reg <= 1'b0;
            wp_valid_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg   <= cmd.rd_issue;
            p_valid_reg    <= s1_valid_reg;
            trow_valid_reg <= row_end;
            wp_valid_reg   <= trow_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_elem_reg  <= cmd.rd_elem;
        p_elem_reg   <= s1_elem_reg;
        trow_row_reg <= p_elem_reg[3:2];
        wp_row_reg   <= trow_row_reg;
    end

    // Element times vector component; translation goes through as times one for points, times zero for normals
    logic signed [31:0] vsel;
    logic signed [63:0] prod_reg;

    always_comb
    begin
        unique case (s1_elem_reg[1:0])
            2'd0:    vsel = v_reg[0];
            2'd1:    vsel = v_reg[1];
            2'd2:    vsel = v_reg[2];
            default: vsel = normal_reg ? 32'sd0 : 32'sd65536;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(ram_rdata) * vsel;
    end

    // Row sum of rounded products
    logic signed [63:0] prod_rnd;
    logic signed [49:0] term;
    logic signed [49:0] t_next;
    logic signed [49:0] t_reg;
    logic signed [31:0] trow_reg;

    assign prod_rnd = (prod_reg + 64'sd32768) >>> 16;
    assign term     = prod_rnd[49:0];
    assign t_next   = (p_elem_reg[1:0] == 2'd0) ? term : t_reg + term;

    always_ff @(posedge clk)
    begin
        if (p_valid_reg)
            t_reg <= t_next;
        if (row_end)
            trow_reg <= sat32(t_next);
    end

    // Weight scaling
    logic signed [17:0] w_s;
    logic signed [49:0] wp_reg;

    assign w_s = {1'b0, w_reg};

    always_ff @(posedge clk)
    begin
        wp_reg <= 50'(trow_reg) * 50'(w_s);
    end

    // Accumulate
    logic signed [47:0] acc_reg [3];
    logic signed [47:0] acc_sel;
    logic signed [49:0] wp_rnd;
    logic signed [49:0] acc_sum;

    always_comb
    begin
        unique case (wp_row_reg)
            2'd0:    acc_sel = acc_reg[0];
            2'd1:    acc_sel = acc_reg[1];
            default: acc_sel = acc_reg[2];
        endcase
    end

    assign wp_rnd  = (wp_reg + 50'sd32768) >>> 16;
    assign acc_sum = 50'(acc_sel) + wp_rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
                acc_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (cmd.emit)
                    acc_reg[i] <= '0;
                else if (wp_valid_reg && (wp_row_reg == 2'(i)))
                    acc_reg[i] <= sat48(acc_sum);
            end
        end
    end

    // Magnitudes and short-vector test
    logic [47:0] mag_c [3];
    logic [7:0]  sq_small;
    logic        all_small;

    always_comb
    begin
        sq_small  = '0;
        all_small = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            mag_c[i]  = acc_reg[i][47] ? 48'(-acc_reg[i]) : acc_reg[i];
            sq_small  = sq_small + 8'(mag_c[i][2:0]) * 8'(mag_c[i][2:0]);
            all_small = all_small && !(|mag_c[i][47:3]);
        end
    end

    // Normalizer registers
    logic [47:0]        m_reg [3];
    logic               sign_reg [3];
    logic signed [31:0] o_reg [3];
    logic [47:0]        m_or;
    logic               m_hi;
    logic [47:0]        m_sel;

    assign m_or = m_reg[0] | m_reg[1] | m_reg[2];
    assign m_hi = |m_or[47:30];

    always_comb
    begin
        unique case (cmd.comp)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            2'd2:    m_sel = m_reg[2];
            default: m_sel = '0;
        endcase
    end

    // Sum of squares, one component a cycle
    logic [61:0] sq_reg;
    logic [59:0] sq_term;

    assign sq_term = m_sel[29:0] * m_sel[29:0];

    // Square root, one result bit a cycle
    logic [62:0] n_reg, r_reg, bit_reg;
    logic [62:0] r_plus;

    assign r_plus = r_reg + bit_reg;

    // Divider, one quotient bit a cycle
    logic [46:0] num;
    logic [31:0] rem_reg;
    logic [17:0] low_reg;
    logic [17:0] q_reg;
    logic [32:0] trial;
    logic [32:0] len33;
    logic        ge;
    logic [17:0] q_next;

    assign num    = {m_sel[29:0], 16'h0000} + 47'(r_reg[30:1]);
    assign trial  = {rem_reg, low_reg[17]};
    assign len33  = 33'(r_reg[30:0]);
    assign ge     = (trial >= len33);
    assign q_next = {q_reg[16:0], ge};

    always_ff @(posedge clk)
    begin
        // Load magnitudes and saturated outputs
        if (cmd.norm_init)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i]    <= mag_c[i];
                sign_reg[i] <= acc_reg[i][47];
                o_reg[i]    <= sat32(50'(acc_reg[i]));
            end
        end
        // Align the largest magnitude into [2^29, 2^30)
        if (cmd.shift_step)
        begin
            for (int i = 0; i < 3; i++)
                m_reg[i] <= m_hi ? (m_reg[i] >> 1) : (m_reg[i] << 1);
        end
        if (cmd.sq_step)
            sq_reg <= (cmd.comp == 2'd0) ? 62'(sq_term) : sq_reg + 62'(sq_term);
        if (cmd.sqrt_init)
        begin
            n_reg   <= 63'(sq_reg);
            r_reg   <= '0;
            bit_reg <= 63'h4000_0000_0000_0000;
        end
        if (cmd.sqrt_step)
        begin
            if (n_reg >= r_plus)
            begin
                n_reg <= n_reg - r_plus;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            rem_reg <= 32'(num[46:18]);
            low_reg <= num[17:0];
            q_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            rem_reg <= ge ? 32'(trial - len33) : trial[31:0];
            low_reg <= low_reg << 1;
            q_reg   <= q_next;
            if (cmd.div_last)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (cmd.comp == 2'(i))
                        o_reg[i] <= sign_reg[i] ? -32'(q_next) : 32'(q_next);
                end
            end
        end
    end

    // Output register
    logic        m_valid_reg;
    logic [95:0] out_data_reg;
    logic        out_norm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (cmd.emit)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {o_reg[2], o_reg[1], o_reg[0]};
            out_norm_reg <= normal_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_norm_reg;

    // Status
    always_comb
    begin
        sts             = '0;
        sts.op          = s_tuser[TUSER_OP];
        sts.bone_ok     = ({1'b0, in_bone} < bone_count_reg) && (32'(in_bone) < NUM_BONES);
        sts.item_normal = normal_reg;
        sts.item_last   = cmd.capture ? s_tlast : last_reg;
        sts.short_now   = all_small && (sq_small < SHORT_SQ_LIMIT);
        sts.aligned     = !m_hi && m_or[29];
        sts.out_free    = !m_valid_reg || m_tready;
    end

endmodule

`default_nettype wire

// ----- sv/lbs_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "linear_blend_skinning_defines.svh"

module lbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic [lbs_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [lbs_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                          s_tlast,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [lbs_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lbs_pkg::M_TUSER_W-1:0] m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    import lbs_pkg::*;

    logic in_beat;
    assign in_beat = s_tvalid && s_tready && (|s_tdata || !(|s_tdata));

    // Stalled result holds
    `LBS_ASSERT_NXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // Matrix load never stalls the input
    `LBS_ASSERT_NXT(a_load_ready, clk, rst_n, in_beat && (s_tuser[TUSER_OP] == OP_LOAD), s_tready, "load stalled input")

    // Last influence starts work that blocks input
    `LBS_ASSERT_NXT(a_last_busy, clk, rst_n, in_beat && (s_tuser[TUSER_OP] == OP_INFL) && s_tlast, !s_tready, "last influence did not block input")

    // A new result appears only as the block returns to idle
    `LBS_ASSERT_IMP(a_emit_idle, clk, rst_n, $rose(m_tvalid), s_tready && !$past(s_tready), "result outside emit step")

endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

`default_nettype wire

// ----- bench/tb_linear_blend_skinning.sv -----
`timescale 1ns / 1ps

module tb_linear_blend_skinning;
    import lbs_pkg::*;

    localparam int NBONES    = 256;
    localparam int NLOAD     = 32;
    localparam int MAX_CYC   = 3000000;
    localparam int SETTLE    = 200;

    typedef struct {
        logic        op;
        logic [7:0]  bone;
        logic [3:0]  elem;
        logic [31:0] value;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [16:0] weight;
        logic        is_normal;
        logic        last;
    } beat_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        nrm;
    } blend_t;

    logic                 clk;
    logic                 rst_n;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_we;
    logic [CFG_W-1:0]     cfg_data;

    linear_blend_skinning #(.NUM_BONES(NBONES)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // Predictor state
    logic [31:0]        mat_mem [NBONES*12];
    logic signed [63:0] acc [3];
    int unsigned        n_bones;

    beat_t  pending[$];
    blend_t expected_blends[$];
    int     errors;
    longint cycles;
    bit     tx_idle_on, rx_idle_on;
    int     rx_hold;

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic longint fshift16(longint x);
        return x >>> 16;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Scale a blended normal to unit length unless it is too short
    function automatic void unit_scale(input longint s[3], output longint o[3]);
        longint unsigned m[3], big, sq, len, q;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = s[i] < 0 ? -s[i] : s[i];
            o[i] = clip(s[i], -64'sd2147483648, 64'sd2147483647);
        end
        big = m[0];
        if (m[1] > big) big = m[1];
        if (m[2] > big) big = m[2];
        if (big < (64'd1 << 31))
        begin
            sq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
            if (sq < 43) return;
        end
        while (big >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            big >>= 1;
        end
        while (big < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            big <<= 1;
        end
        sq = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        len = root64(sq);
        for (int i = 0; i < 3; i++)
        begin
            q = (m[i] * 65536 + (len >> 1)) / len;
            o[i] = s[i] < 0 ? -longint'(q) : longint'(q);
        end
    endfunction

    // Advance the skinning model by one accepted beat
    task automatic skin_predict(beat_t b);
        longint v[3], t, p, w, s[3], o[3];
        blend_t e;
        if (b.op == OP_LOAD)
        begin
            if (b.elem < 12)
                mat_mem[b.bone*12 + b.elem] = b.value;
            return;
        end
        w = b.weight > 65536 ? 65536 : b.weight;
        v[0] = longint'($signed(b.vx));
        v[1] = longint'($signed(b.vy));
        v[2] = longint'($signed(b.vz));
        if (b.bone < n_bones)
        begin
            for (int r = 0; r < 3; r++)
            begin
                t = 0;
                for (int c = 0; c < 3; c++)
                    t += fshift16(longint'($signed(mat_mem[b.bone*12 + r*4 + c])) * v[c]
                                  + 32768);
                if (!b.is_normal)
                    t += longint'($signed(mat_mem[b.bone*12 + r*4 + 3]));
                t = clip(t, -64'sd2147483648, 64'sd2147483647);
                p = fshift16(t * w + 32768);
                acc[r] = clip(acc[r] + p, -64'sh800000000000, 64'sh7FFFFFFFFFFF);
            end
        end
        if (!b.last) return;
        for (int r = 0; r < 3; r++) s[r] = acc[r];
        if (b.is_normal)
            unit_scale(s, o);
        else
            for (int r = 0; r < 3; r++) o[r] = clip(s[r], -64'sd2147483648, 64'sd2147483647);
        e.x = o[0][31:0];
        e.y = o[1][31:0];
        e.z = o[2][31:0];
        e.nrm = b.is_normal;
        expected_blends.push_back(e);
        for (int r = 0; r < 3; r++) acc[r] = 0;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Driver: offer queued beats, predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                skin_predict(pending.pop_front());
            if ((!s_tvalid || s_tready) || 1)
            begin
                if ((s_tvalid && s_tready) || !s_tvalid)
                begin
                    if (pending.size() > 0 && (!tx_idle_on || $urandom_range(99) >= 19))
                    begin
                        s_tvalid <= 1'b1;
                        s_tdata  <= {3'd0, pending[0].weight, pending[0].vz, pending[0].vy,
                                     pending[0].vx, pending[0].value, pending[0].elem,
                                     pending[0].bone};
                        s_tuser  <= {pending[0].is_normal, pending[0].op};
                        s_tlast  <= pending[0].last;
                    end
                    else
                        s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver ready with random idling and a long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_hold > 0)
            begin
                rx_hold <= rx_hold - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !rx_idle_on || $urandom_range(99) >= 19;
        end
    end

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        blend_t e;
        cycles++;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_blends.size() == 0)
            begin
                report_mismatch("unexpected beat", m_tdata[31:0], 32'h0);
            end
            else
            begin
                e = expected_blends.pop_front();
                if (m_tdata[31:0] !== e.x) report_mismatch("out_x", m_tdata[31:0], e.x);
                if (m_tdata[63:32] !== e.y) report_mismatch("out_y", m_tdata[63:32], e.y);
                if (m_tdata[95:64] !== e.z) report_mismatch("out_z", m_tdata[95:64], e.z);
                if (m_tuser[0] !== e.nrm)
                    report_mismatch("out_is_normal", 32'(m_tuser[0]), 32'(e.nrm));
            end
        end
        if (cycles > MAX_CYC)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(5))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return $urandom_range(131072) - 65536;
            3: return $urandom_range(1310720) - 655360;
            default: return $urandom;
        endcase
    endfunction

    function automatic beat_t load_beat(int bone, int el, logic [31:0] val);
        beat_t b;
        b = '{default: 0};
        b.op = OP_LOAD;
        b.bone = 8'(bone);
        b.elem = 4'(el);
        b.value = val;
        b.vx = $urandom; b.vy = $urandom; b.vz = $urandom;
        b.weight = 17'($urandom);
        b.is_normal = 1'($urandom);
        b.last = 1'($urandom);
        return b;
    endfunction

    function automatic beat_t infl_beat(int bone, bit nrm, bit lst);
        beat_t b;
        b.op = OP_INFL;
        b.bone = 8'(bone);
        b.elem = 4'($urandom);
        b.value = $urandom;
        b.vx = rnd_val(); b.vy = rnd_val(); b.vz = rnd_val();
        case ($urandom_range(3))
            0: b.weight = 17'd65536;
            1: b.weight = 17'h1FFFF - 17'($urandom_range(3));
            default: b.weight = 17'($urandom_range(65536));
        endcase
        b.is_normal = nrm;
        b.last = lst;
        return b;
    endfunction

    task automatic wait_drained();
        while (pending.size() > 0 || s_tvalid || expected_blends.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_bones(int n);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= CFG_W'(n);
        @(posedge clk);
        cfg_we   <= 1'b0;
        n_bones = n > NBONES ? NBONES : n;
    endtask

    initial
    begin
        beat_t b;
        int    nb, cnt, ph, lim;
        errors = 0; cycles = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0; s_tlast = 1'b0;
        m_tready = 1'b0; cfg_we = 1'b0; cfg_data = '0;
        tx_idle_on = 1'b0; rx_idle_on = 1'b0; rx_hold = 0;
        for (int i = 0; i < 3; i++) acc[i] = 0;
        n_bones = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Load the matrices of the bones that influences may name
        for (int bn = 0; bn < NLOAD; bn++)
            for (int el = 0; el < 12; el++)
                pending.push_back(load_beat(bn, el,
                    (bn == 0) ? ((el % 5 == 0) ? 32'h00010000 : 32'h0) : rnd_val()));
        // Bad element loads are ignored
        pending.push_back(load_beat(3, 12, 32'hDEADBEEF));
        pending.push_back(load_beat(255, 15, 32'h12345678));
        wait_drained();

        // Directed: bone_count zero skips all, then extremes
        set_bones(0);
        pending.push_back(infl_beat(0, 0, 1));
        wait_drained();
        set_bones(256);
        b = infl_beat(0, 0, 1); b.vx = 32'h7FFFFFFF; b.vy = 32'h80000000; b.vz = 0;
        b.weight = 17'd65536; pending.push_back(b);
        b = infl_beat(0, 1, 1); b.vx = 32'h00010000; b.vy = 0; b.vz = 0;
        pending.push_back(b);
        b = infl_beat(0, 1, 1); b.vx = 1; b.vy = 2; b.vz = 3;
        b.weight = 17'd65536; pending.push_back(b);   // short normal
        b = infl_beat(0, 1, 1); b.vx = 0; b.vy = 0; b.vz = 0; pending.push_back(b);
        b = infl_beat(NLOAD - 1, 0, 0); b.weight = 17'h1FFFF; pending.push_back(b);
        b = infl_beat(NLOAD - 1, 1, 1); pending.push_back(b);  // mixed kinds
        for (int i = 0; i < 6; i++)
        begin
            b = infl_beat($urandom_range(1, NLOAD - 1), 0, 0);
            b.vx = 32'h7FFFFFFF; b.vy = 32'h7FFFFFFF; b.vz = 32'h80000000;
            b.weight = 17'd65536; pending.push_back(b);
        end
        pending.push_back(infl_beat(7, 0, 1));
        wait_drained();

        // Random phases over several bone counts
        tx_idle_on = 1'b1; rx_idle_on = 1'b1;
        for (ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: nb = 1;
                1: nb = 511;
                2: nb = $urandom_range(2, 255);
                3: nb = 128;
                default: nb = 256;
            endcase
            set_bones(nb);
            lim = (nb < NLOAD ? nb : NLOAD) - 1;
            if (ph == 2)
            begin
                tx_idle_on = 1'b0; rx_idle_on = 1'b0;
            end
            else
            begin
                tx_idle_on = 1'b1; rx_idle_on = 1'b1;
            end
            cnt = 0;
            while (cnt < 225)
            begin
                int k;
                bit nrm;
                k = $urandom_range(1, 4);
                nrm = 1'($urandom);
                for (int i = 0; i < k; i++)
                begin
                    b = infl_beat((nb < 256 && $urandom_range(9) == 0) ? $urandom_range(255, nb)
                                  : $urandom_range(lim),
                                  $urandom_range(5) == 0 ? !nrm : nrm, i == k - 1);
                    pending.push_back(b);
                    cnt++;
                end
                if ($urandom_range(19) == 0)
                begin
                    pending.push_back(load_beat($urandom_range(1, NLOAD - 1),
                                                $urandom_range(15), rnd_val()));
                    cnt++;
                end
            end
            if (ph == 3)
                rx_hold = 3000;
            wait_drained();
        end

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_ram.sv
sv/lbs_ctrl.sv
sv/lbs_dp.sv
sv/linear_blend_skinning.sv
sv/lbs_checker.sv
bench/tb_linear_blend_skinning.sv
